// ===== sv/lfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the loss function accumulator.
// No dependencies; imported by every module of the block.
package lfa_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int COL_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;
  localparam int LN_STEPS    = 20;
  localparam int DIV_STEPS   = 64;
  localparam int CNT_W       = 6;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 1'd1;

  typedef enum logic [1:0] {
    MODE_MSE = 2'd0,
    MODE_MAE = 2'd1,
    MODE_BCE = 2'd2,
    MODE_CCE = 2'd3
  } loss_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLASS = 2'd1,
    ERR_COLS  = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    LN_P      = 2'd0,
    LN_Q      = 2'd1,
    LN_CHOSEN = 2'd2
  } ln_sel_t;

  typedef enum logic [1:0] {
    DIV_ROW   = 2'd0,
    DIV_BATCH = 2'd1,
    DIV_TOTAL = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SQ,
    ST_LN_INIT,
    ST_LN_STEP,
    ST_LN_MUL,
    ST_LN_FIN,
    ST_BCE_M1,
    ST_BCE_M0,
    ST_ROW_ADD,
    ST_ROW_END,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_FIN,
    ST_ACC,
    ST_WAIT_OUT
  } state_t;

  typedef struct packed {
    logic              kind;
    logic signed [23:0] predicted;
    logic signed [23:0] truth;
    logic [7:0]        class_index;
    logic              last_in_row;
    logic              last_in_batch;
  } in_word_t;

  typedef struct packed {
    logic [31:0] sample_loss;
    logic [31:0] batch_mean;
    logic [31:0] accumulated_mean;
    logic        batch_done;
    logic [1:0]  error;
  } out_word_t;

  typedef struct packed {
    logic     load;
    logic     sq;
    logic     ln_init;
    logic     ln_step;
    logic     ln_mul;
    logic     ln_fin;
    ln_sel_t  ln_sel;
    logic     bce_m1;
    logic     bce_m0;
    logic     row_add;
    logic     row_end;
    logic     div_init;
    logic     div_step;
    logic     div_fin;
    div_sel_t div_sel;
    logic     acc;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic       kind;
    logic       last_row;
    logic       row_err;
    logic       row_neg;
    loss_mode_t mode;
  } dp_status_t;

  // clamp a Q7.16 probability to one LSB inside (0, 1)
  function automatic logic [15:0] prob_clamp(input logic signed [23:0] p);
    if (p < 24'sd1) return 16'd1;
    else if (p > 24'sd65535) return 16'hFFFF;
    else return p[15:0];
  endfunction

endpackage

// ===== sv/lfa_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the loss accumulator: handshakes and datapath commands.
// Depends on lfa_pkg.
module lfa_ctrl
  import lfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  ln_sel_t           ln_ph_r, ln_ph_nxt;
  div_sel_t          div_ph_r, div_ph_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ln_ph_nxt  = ln_ph_r;
    div_ph_nxt = div_ph_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (status.kind) begin
          state_nxt = ST_IDLE;
        end else begin
          case (status.mode)
            MODE_MSE, MODE_MAE: state_nxt = ST_SQ;
            MODE_BCE: begin
              state_nxt = ST_LN_INIT;
              ln_ph_nxt = LN_P;
            end
            default: state_nxt = ST_ROW_ADD;
          endcase
        end
      end
      ST_SQ:      state_nxt = ST_ROW_ADD;
      ST_LN_INIT: begin
        state_nxt = ST_LN_STEP;
        cnt_nxt   = '0;
      end
      ST_LN_STEP: begin
        if (cnt_r == CNT_W'(LN_STEPS - 1)) state_nxt = ST_LN_MUL;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_LN_MUL:  state_nxt = ST_LN_FIN;
      ST_LN_FIN: begin
        case (ln_ph_r)
          LN_P: begin
            state_nxt = ST_LN_INIT;
            ln_ph_nxt = LN_Q;
          end
          LN_Q:    state_nxt = ST_BCE_M1;
          default: state_nxt = ST_ACC;
        endcase
      end
      ST_BCE_M1:  state_nxt = ST_BCE_M0;
      ST_BCE_M0:  state_nxt = ST_ROW_ADD;
      ST_ROW_ADD: state_nxt = status.last_row ? ST_ROW_END : ST_IDLE;
      ST_ROW_END: begin
        if (status.row_err) begin
          state_nxt = ST_ACC;
        end else if (status.mode == MODE_CCE) begin
          state_nxt = ST_LN_INIT;
          ln_ph_nxt = LN_CHOSEN;
        end else if (status.row_neg) begin
          state_nxt = ST_ACC;
        end else begin
          state_nxt  = ST_DIV_INIT;
          div_ph_nxt = DIV_ROW;
        end
      end
      ST_DIV_INIT: begin
        state_nxt = ST_DIV_STEP;
        cnt_nxt   = '0;
      end
      ST_DIV_STEP: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DIV_FIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_DIV_FIN: begin
        case (div_ph_r)
          DIV_ROW: state_nxt = ST_ACC;
          DIV_BATCH: begin
            state_nxt  = ST_DIV_INIT;
            div_ph_nxt = DIV_TOTAL;
          end
          default: state_nxt = ST_WAIT_OUT;
        endcase
      end
      ST_ACC: begin
        state_nxt  = ST_DIV_INIT;
        div_ph_nxt = DIV_BATCH;
      end
      ST_WAIT_OUT: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.ln_sel  = ln_ph_r;
    cmd.div_sel = div_ph_r;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQ:       cmd.sq = 1'b1;
      ST_LN_INIT:  cmd.ln_init = 1'b1;
      ST_LN_STEP:  cmd.ln_step = 1'b1;
      ST_LN_MUL:   cmd.ln_mul = 1'b1;
      ST_LN_FIN:   cmd.ln_fin = 1'b1;
      ST_BCE_M1:   cmd.bce_m1 = 1'b1;
      ST_BCE_M0:   cmd.bce_m0 = 1'b1;
      ST_ROW_ADD:  cmd.row_add = 1'b1;
      ST_ROW_END:  cmd.row_end = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV_STEP: cmd.div_step = 1'b1;
      ST_DIV_FIN:  cmd.div_fin = 1'b1;
      ST_ACC:      cmd.acc = 1'b1;
      ST_WAIT_OUT: cmd.emit = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ln_ph_r     <= LN_P;
      div_ph_r    <= DIV_ROW;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ln_ph_r     <= ln_ph_nxt;
      div_ph_r    <= div_ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/lfa_dp.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, element terms, -ln unit, radix-2 divider,
// row/batch/total accumulators and the output register. Depends on lfa_pkg.
module lfa_dp
  import lfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_word_t              in_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output out_word_t             out_data
);

  // configuration and architectural state
  loss_mode_t         mode_r;
  logic [COL_W-1:0]   cols_r;
  logic [COL_W-1:0]   col_cnt_r;
  logic signed [47:0] row_sum_r;
  logic [23:0]        chosen_r;
  logic [63:0]        batch_sum_r;
  logic [31:0]        batch_rows_r;
  logic [63:0]        total_sum_r;
  logic [31:0]        total_rows_r;

  // working registers
  in_word_t           item_r;
  logic signed [49:0] term_r;
  logic [30:0]        ln_y_r;
  logic [19:0]        ln_f_r;
  logic [3:0]         ln_e_r;
  logic [56:0]        ln_prod_r;
  logic [20:0]        l1_r, l0_r;
  logic signed [47:0] p1_r, p0_r;
  logic [31:0]        sample_r;
  err_code_t          err_r;
  logic [63:0]        dv_q_r;
  logic [31:0]        dv_rem_r;
  logic [31:0]        dv_div_r;
  logic [31:0]        bmean_r, tmean_r;
  out_word_t          out_r;

  // effective column count, 1..MAX_COLUMNS
  logic [COL_W-1:0] eff_cols;
  always_comb begin
    if (cols_r == '0) eff_cols = COL_W'(1);
    else if (cols_r > COL_W'(MAX_COLUMNS)) eff_cols = COL_W'(MAX_COLUMNS);
    else eff_cols = cols_r;
  end

  err_code_t row_err;
  always_comb begin
    row_err = ERR_NONE;
    if (mode_r == MODE_CCE) begin
      if (eff_cols < COL_W'(2)) row_err = ERR_COLS;
      else if ({1'b0, item_r.class_index} >= eff_cols) row_err = ERR_CLASS;
    end
  end

  assign status.kind     = item_r.kind;
  assign status.last_row = item_r.last_in_row;
  assign status.row_err  = (row_err != ERR_NONE);
  assign status.row_neg  = row_sum_r[47];
  assign status.mode     = mode_r;

  // element term for squared / absolute error
  logic signed [24:0] diff;
  logic signed [49:0] diff_sq;
  logic signed [49:0] diff_abs;
  assign diff     = 25'(item_r.truth) - 25'(item_r.predicted);
  assign diff_sq  = 50'(diff) * 50'(diff);
  assign diff_abs = diff[24] ? -50'(diff) : 50'(diff);

  // -ln unit: normalize, 20 squarings, scale by ln2, round
  logic [15:0] pc, ln_arg, ln_norm;
  logic [3:0]  ln_e;
  logic [61:0] ln_sq;
  logic [31:0] ln_t;
  logic [24:0] ln_l2;
  logic [57:0] ln_rnd;
  logic [20:0] ln_res;

  assign pc = prob_clamp(item_r.predicted);

  always_comb begin
    case (cmd.ln_sel)
      LN_P:    ln_arg = pc;
      LN_Q:    ln_arg = 16'(17'd65536 - {1'b0, pc});
      default: ln_arg = prob_clamp($signed(chosen_r));
    endcase
  end

  always_comb begin
    ln_e = '0;
    for (int i = 0; i < 16; i++) begin
      if (ln_arg[i]) ln_e = 4'(i);
    end
  end

  assign ln_norm = ln_arg << (4'd15 - ln_e);
  assign ln_sq   = 62'(ln_y_r) * 62'(ln_y_r);
  assign ln_t    = ln_sq[61:30];
  assign ln_l2   = {5'(5'd16 - {1'b0, ln_e_r}), 20'd0} - {5'd0, ln_f_r};
  assign ln_rnd  = {1'b0, ln_prod_r} + (58'd1 << 35);
  assign ln_res  = ln_rnd[56:36];

  // binary cross entropy products
  logic signed [24:0] one_minus_t;
  logic signed [48:0] bce_s;
  logic signed [48:0] bce_term;
  assign one_minus_t = 25'sd65536 - 25'(item_r.truth);
  assign bce_s       = 49'(p1_r) + 49'(p0_r);
  // divide by 65536, truncating toward zero
  assign bce_term    = bce_s[48] ? ((bce_s + 49'sd65535) >>> 16) : (bce_s >>> 16);

  logic signed [49:0] term;
  logic signed [49:0] row_acc;
  always_comb begin
    case (mode_r)
      MODE_BCE: term = 50'(bce_term);
      MODE_CCE: term = '0;
      default:  term = term_r;
    endcase
  end
  assign row_acc = 50'(row_sum_r) + term;

  // restoring divider, one quotient bit per cycle
  logic [32:0] dv_part;
  logic        dv_ge;
  assign dv_part = {dv_rem_r, dv_q_r[63]};
  assign dv_ge   = dv_part >= {1'b0, dv_div_r};

  logic [64:0] bsum_add, tsum_add;
  assign bsum_add = {1'b0, batch_sum_r} + 65'(sample_r);
  assign tsum_add = {1'b0, total_sum_r} + 65'(sample_r);

  // config and state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MSE;
      cols_r       <= COL_W'(1);
      col_cnt_r    <= '0;
      row_sum_r    <= '0;
      chosen_r     <= '0;
      batch_sum_r  <= '0;
      batch_rows_r <= '0;
      total_sum_r  <= '0;
      total_rows_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOSS_MODE: mode_r <= loss_mode_t'(cfg_data[1:0]);
          CFG_COLUMNS:   cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && in_data.kind) begin
        total_sum_r  <= '0;
        total_rows_r <= '0;
      end
      if (cmd.row_add) begin
        if (!row_acc[49] && row_acc[48:47] != 2'b00)
          row_sum_r <= {1'b0, {47{1'b1}}};
        else if (row_acc[49] && row_acc[48:47] != 2'b11)
          row_sum_r <= {1'b1, 47'd0};
        else
          row_sum_r <= row_acc[47:0];
        if (col_cnt_r < COL_W'(MAX_COLUMNS)) col_cnt_r <= col_cnt_r + 1'b1;
        if (mode_r == MODE_CCE && col_cnt_r == {1'b0, item_r.class_index})
          chosen_r <= item_r.predicted;
      end
      if (cmd.acc && err_r == ERR_NONE) begin
        batch_sum_r <= bsum_add[64] ? '1 : bsum_add[63:0];
        total_sum_r <= tsum_add[64] ? '1 : tsum_add[63:0];
        if (batch_rows_r != '1) batch_rows_r <= batch_rows_r + 1'b1;
        if (total_rows_r != '1) total_rows_r <= total_rows_r + 1'b1;
      end
      if (cmd.emit) begin
        row_sum_r <= '0;
        chosen_r  <= '0;
        col_cnt_r <= '0;
        if (item_r.last_in_batch) begin
          batch_sum_r  <= '0;
          batch_rows_r <= '0;
        end
      end
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.sq) term_r <= (mode_r == MODE_MSE) ? $signed({16'd0, diff_sq[49:16]}) : diff_abs;
    if (cmd.ln_init) begin
      ln_y_r <= {ln_norm, 15'd0};
      ln_f_r <= '0;
      ln_e_r <= ln_e;
    end
    if (cmd.ln_step) begin
      if (ln_t[31]) begin
        ln_y_r <= ln_t[31:1];
        ln_f_r <= {ln_f_r[18:0], 1'b1};
      end else begin
        ln_y_r <= ln_t[30:0];
        ln_f_r <= {ln_f_r[18:0], 1'b0};
      end
    end
    if (cmd.ln_mul) ln_prod_r <= 57'(ln_l2) * 57'(LN2_Q32);
    if (cmd.ln_fin) begin
      case (cmd.ln_sel)
        LN_P:    l1_r <= ln_res;
        LN_Q:    l0_r <= ln_res;
        default: sample_r <= 32'(ln_res);
      endcase
    end
    if (cmd.bce_m1) p1_r <= 48'(item_r.truth) * 48'($signed({1'b0, l1_r}));
    if (cmd.bce_m0) p0_r <= 48'(one_minus_t) * 48'($signed({1'b0, l0_r}));
    if (cmd.row_end) begin
      err_r    <= row_err;
      sample_r <= '0;
    end
    if (cmd.div_init) begin
      dv_rem_r <= '0;
      case (cmd.div_sel)
        DIV_ROW: begin
          dv_q_r   <= 64'(row_sum_r[46:0]);
          dv_div_r <= 32'(eff_cols);
        end
        DIV_BATCH: begin
          dv_q_r   <= batch_sum_r;
          dv_div_r <= batch_rows_r;
        end
        default: begin
          dv_q_r   <= total_sum_r;
          dv_div_r <= total_rows_r;
        end
      endcase
    end
    if (cmd.div_step) begin
      dv_rem_r <= dv_ge ? 32'(dv_part - {1'b0, dv_div_r}) : dv_part[31:0];
      dv_q_r   <= {dv_q_r[62:0], dv_ge};
    end
    if (cmd.div_fin) begin
      case (cmd.div_sel)
        DIV_ROW:   sample_r <= (dv_q_r[63:32] != '0) ? '1 : dv_q_r[31:0];
        DIV_BATCH: bmean_r  <= (dv_div_r == '0) ? '0 : dv_q_r[31:0];
        default:   tmean_r  <= (dv_div_r == '0) ? '0 : dv_q_r[31:0];
      endcase
    end
    if (cmd.emit) begin
      out_r.sample_loss      <= sample_r;
      out_r.batch_mean       <= bmean_r;
      out_r.accumulated_mean <= tmean_r;
      out_r.batch_done       <= item_r.last_in_batch;
      out_r.error            <= err_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/loss_function_accumulator.sv =====
`timescale 1ns / 1ps
// Loss accumulator top: MSE / MAE / BCE / sparse CCE over rows of a stream.
// Depends on lfa_pkg, lfa_ctrl and lfa_dp.
//
//   port group | dir | what it carries
//   in_*       | in  | one element word or a clear word (in_word_t)
//   out_*      | out | one row result word (out_word_t)
//   cfg_*      | in  | register write: 0 loss_mode, 1 columns
//
// One word at a time. MSE/MAE element: dispatch, term, row add; CCE element:
// dispatch, row add; clear word: dispatch. BCE element: two -ln evaluations (20
// squarings each on one 31x31 multiplier), two products, row add. Row end adds
// row end, accumulate and output load plus a row divide (a -ln in CCE, none on
// error or negative-sum rows) and two mean divides on the shared radix-2 divider.
// Synchronous active-low reset clears all sums and counts; no clearing pass.
// The result sits in an output register; the next word is taken while it waits,
// and a later result holds until that register is free.
module loss_function_accumulator
  import lfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // one word in flight: busy right after taking a word
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous still in flight");

  // error rows carry no loss
  a_err_zero_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error != ERR_NONE |-> out_data.sample_loss == '0)
    else $error("error row with nonzero sample loss");

  // a result is loaded only into a free output slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwritten before it was taken");
`endif

endmodule
